// File: sv/fsee_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the floating-point stack evaluator.
package fsee_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_DIV   = 3'd4,
    CMD_PRINT = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ADDR_TOP  = 2'd0,
    ADDR_M1   = 2'd1,
    ADDR_M2   = 2'd2
  } addr_sel_e;

  typedef struct packed {
    logic      latch_in;
    logic      mem_we;
    logic      wr_fpu;
    addr_sel_e addr_sel;
    logic      cap_a;
    logic      fpu_start;
    logic      depth_inc;
    logic      depth_dec;
    logic      depth_clr;
    logic      out_load;
    status_e   out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       under2;
    logic       empty;
    logic       last;
    logic       fpu_done;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: sv/fsee_fpu.sv
`timescale 1ns / 1ps
// Iterative binary64 add, subtract, multiply and divide with round to nearest even.
module fsee_fpu (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fsee_pkg::cmd_e op_i,
  input  logic [63:0]    a_i,
  input  logic [63:0]    b_i,
  output logic           done_o,
  output logic [63:0]    res_o
);
  import fsee_pkg::*;

  localparam logic [63:0] QNAN_DEF = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET    = 64'h0008_0000_0000_0000;

  typedef enum logic [2:0] {
    F_IDLE, F_ADD, F_PRE, F_MUL, F_DIV, F_NORM, F_RND, F_FIN
  } fstate_e;

  fstate_e            state_q;
  cmd_e               op_q;
  logic               s_q, sub_q, st_q;
  logic signed [12:0] ea_q, eb_q, e_q;
  logic [52:0]        ma_q, mb_q;
  logic [10:0]        d_q;
  logic [105:0]       p_q;
  logic [53:0]        rem_q;
  logic [63:0]        q_q, frac_q, res_q;
  logic [5:0]         cnt_q;

  // operand decode
  logic [10:0]        a_e11, b_e11;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sb_eff, sx, a_big;
  logic signed [12:0] a_eb, b_eb;
  logic [52:0]        a_m, b_m;
  logic               spec;
  logic [63:0]        spec_val;

  always_comb begin
    a_e11  = a_i[62:52];
    b_e11  = b_i[62:52];
    a_nan  = (&a_e11) && (|a_i[51:0]);
    b_nan  = (&b_e11) && (|b_i[51:0]);
    a_inf  = (&a_e11) && !(|a_i[51:0]);
    b_inf  = (&b_e11) && !(|b_i[51:0]);
    a_zero = !(|a_i[62:0]);
    b_zero = !(|b_i[62:0]);
    a_eb   = signed'({2'b00, (a_e11 == 11'd0) ? 11'd1 : a_e11});
    b_eb   = signed'({2'b00, (b_e11 == 11'd0) ? 11'd1 : b_e11});
    a_m    = {|a_e11, a_i[51:0]};
    b_m    = {|b_e11, b_i[51:0]};
    sb_eff = b_i[63] ^ (op_i == CMD_SUB);
    sx     = a_i[63] ^ b_i[63];
    a_big  = a_i[62:0] >= b_i[62:0];
  end

  always_comb begin
    spec     = 1'b1;
    spec_val = '0;
    if (op_i == CMD_MUL) begin
      if (a_nan)                                        spec_val = a_i | QUIET;
      else if (b_nan)                                   spec_val = b_i | QUIET;
      else if ((a_inf && b_zero) || (a_zero && b_inf))  spec_val = QNAN_DEF;
      else if (a_inf || b_inf)                          spec_val = {sx, 11'h7FF, 52'd0};
      else if (a_zero || b_zero)                        spec_val = {sx, 63'd0};
      else                                              spec     = 1'b0;
    end else if (op_i == CMD_DIV) begin
      if (b_zero) begin
        if (a_nan)       spec_val = a_i | QUIET;
        else if (a_zero) spec_val = QNAN_DEF;
        else             spec_val = {sx, 11'h7FF, 52'd0};
      end else if (a_nan)          spec_val = a_i | QUIET;
      else if (b_nan)              spec_val = b_i | QUIET;
      else if (a_inf && b_inf)     spec_val = QNAN_DEF;
      else if (a_inf)              spec_val = {sx, 11'h7FF, 52'd0};
      else if (b_inf || a_zero)    spec_val = {sx, 63'd0};
      else                         spec     = 1'b0;
    end else begin
      if (a_nan)                   spec_val = a_i | QUIET;
      else if (b_nan)              spec_val = b_i | QUIET;
      else if (a_inf && b_inf)     spec_val = (a_i[63] == sb_eff) ? a_i : QNAN_DEF;
      else if (a_inf)              spec_val = a_i;
      else if (b_inf)              spec_val = {sb_eff, 11'h7FF, 52'd0};
      else                         spec     = 1'b0;
    end
  end

  // add step: alignment with sticky jam, then add or subtract
  logic [63:0] x_full, y_full, y_sh, sum;
  logic        y_st;
  always_comb begin
    x_full = {1'b0, ma_q, 10'd0};
    y_full = {1'b0, mb_q, 10'd0};
    if (d_q >= 11'd64) begin
      y_sh = '0;
      y_st = |mb_q;
    end else begin
      y_sh = y_full >> d_q[5:0];
      y_st = |(y_full & ((64'd1 << d_q[5:0]) - 64'd1));
    end
    sum = sub_q ? (x_full - (y_sh | {63'd0, y_st})) : (x_full + (y_sh | {63'd0, y_st}));
  end

  // multiply and divide steps
  logic [53:0]  msum;
  logic [105:0] p_d;
  logic         ge;
  logic [53:0]  rem_sub;
  logic [63:0]  q_d;
  always_comb begin
    msum    = {1'b0, p_q[105:53]} + (p_q[0] ? {1'b0, ma_q} : 54'd0);
    p_d     = {msum, p_q[52:1]};
    ge      = rem_q >= {1'b0, mb_q};
    rem_sub = ge ? (rem_q - {1'b0, mb_q}) : rem_q;
    q_d     = {q_q[62:0], ge};
  end

  // rounding
  logic        rup;
  logic [63:0] rnd_val;
  always_comb begin
    rup = frac_q[9] && ((|frac_q[8:0]) || st_q || frac_q[10]);
    if (frac_q[62] && (e_q >= 13'sd2047))
      rnd_val = {s_q, 11'h7FF, 52'd0};
    else
      rnd_val = {s_q, frac_q[62] ? e_q[10:0] : 11'd0, frac_q[61:10]} + {63'd0, rup};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (start_i) begin
            op_q <= op_i;
            if (spec) begin
              res_q   <= spec_val;
              state_q <= F_FIN;
            end else if (op_i == CMD_MUL || op_i == CMD_DIV) begin
              s_q     <= sx;
              ea_q    <= a_eb;
              eb_q    <= b_eb;
              ma_q    <= a_m;
              mb_q    <= b_m;
              state_q <= F_PRE;
            end else begin
              s_q     <= a_big ? a_i[63] : sb_eff;
              e_q     <= a_big ? a_eb : b_eb;
              ma_q    <= a_big ? a_m : b_m;
              mb_q    <= a_big ? b_m : a_m;
              d_q     <= a_big ? (a_eb[10:0] - b_eb[10:0]) : (b_eb[10:0] - a_eb[10:0]);
              sub_q   <= a_i[63] ^ sb_eff;
              state_q <= F_ADD;
            end
          end
        end
        F_ADD: begin
          frac_q  <= sum;
          st_q    <= 1'b0;
          if (sub_q && sum == 64'd0) s_q <= 1'b0;
          state_q <= F_NORM;
        end
        F_PRE: begin
          if (ma_q[52:37] == 16'd0) begin
            ma_q <= ma_q << 16;
            ea_q <= ea_q - 13'sd16;
          end else if (!ma_q[52]) begin
            ma_q <= ma_q << 1;
            ea_q <= ea_q - 13'sd1;
          end
          if (mb_q[52:37] == 16'd0) begin
            mb_q <= mb_q << 16;
            eb_q <= eb_q - 13'sd16;
          end else if (!mb_q[52]) begin
            mb_q <= mb_q << 1;
            eb_q <= eb_q - 13'sd1;
          end
          if (ma_q[52] && mb_q[52]) begin
            cnt_q <= '0;
            p_q   <= {53'd0, mb_q};
            rem_q <= {1'b0, ma_q};
            q_q   <= '0;
            state_q <= (op_q == CMD_MUL) ? F_MUL : F_DIV;
          end
        end
        F_MUL: begin
          p_q   <= p_d;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd52) begin
            frac_q  <= p_d[105:42];
            st_q    <= |p_d[41:0];
            e_q     <= ea_q + eb_q - 13'sd1023;
            state_q <= F_NORM;
          end
        end
        F_DIV: begin
          rem_q <= {rem_sub[52:0], 1'b0};
          q_q   <= q_d;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd62) begin
            frac_q  <= q_d;
            st_q    <= rem_sub != 54'd0;
            e_q     <= ea_q - eb_q + 13'sd1023;
            state_q <= F_NORM;
          end
        end
        F_NORM: begin
          if (frac_q[63]) begin
            frac_q <= frac_q >> 1;
            st_q   <= st_q | frac_q[0];
            e_q    <= e_q + 13'sd1;
          end else if (e_q < 13'sd1) begin
            if (e_q < -13'sd62) begin
              frac_q <= '0;
              st_q   <= st_q | (|frac_q);
              e_q    <= 13'sd1;
            end else if (e_q < -13'sd14) begin
              frac_q <= frac_q >> 16;
              st_q   <= st_q | (|frac_q[15:0]);
              e_q    <= e_q + 13'sd16;
            end else begin
              frac_q <= frac_q >> 1;
              st_q   <= st_q | frac_q[0];
              e_q    <= e_q + 13'sd1;
            end
          end else if (frac_q != 64'd0 && !frac_q[62] && e_q > 13'sd1) begin
            if (frac_q[62:47] == 16'd0 && e_q > 13'sd16) begin
              frac_q <= frac_q << 16;
              e_q    <= e_q - 13'sd16;
            end else begin
              frac_q <= frac_q << 1;
              e_q    <= e_q - 13'sd1;
            end
          end else begin
            state_q <= F_RND;
          end
        end
        F_RND: begin
          res_q   <= rnd_val;
          state_q <= F_FIN;
        end
        F_FIN: state_q <= F_IDLE;
      endcase
    end
  end

  assign done_o = state_q == F_FIN;
  assign res_o  = res_q;

endmodule

// File: sv/fsee_dp.sv
`timescale 1ns / 1ps
// Datapath: operand stack memory, depth counter, input and output registers, FPU.
module fsee_dp #(
  parameter int unsigned STACK_DEPTH = fsee_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          command_i,
  input  logic [63:0]         push_value_i,
  input  logic                program_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [63:0]         printed_value_o,
  output logic [1:0]          status_o,
  input  fsee_pkg::ctrl_cmd_t cmd_i,
  output fsee_pkg::dp_stat_t  stat_o
);
  import fsee_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic [2:0]    cmd_q;
  logic [63:0]   val_q, rd_q, a_q, out_val_q;
  logic          end_q, out_valid_q;
  status_e       out_status_q;
  logic [DW-1:0] depth_q, dm1, dm2;
  logic [AW-1:0] addr;
  logic [63:0]   mem [STACK_DEPTH];
  logic          fpu_done;
  logic [63:0]   fpu_res;

  always_comb begin
    dm1 = depth_q - DW'(1);
    dm2 = depth_q - DW'(2);
    unique case (cmd_i.addr_sel)
      ADDR_TOP: addr = depth_q[AW-1:0];
      ADDR_M1:  addr = dm1[AW-1:0];
      ADDR_M2:  addr = dm2[AW-1:0];
      default:  addr = depth_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem[addr] <= cmd_i.wr_fpu ? fpu_res : val_q;
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q <= command_i;
      val_q <= push_value_i;
      end_q <= program_end_i;
    end
    if (cmd_i.cap_a) a_q <= rd_q;
    if (cmd_i.out_load) begin
      out_val_q    <= (cmd_i.out_status == ST_OK) ? rd_q : 64'd0;
      out_status_q <= cmd_i.out_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.depth_clr)      depth_q <= '0;
      else if (cmd_i.depth_inc) depth_q <= depth_q + DW'(1);
      else if (cmd_i.depth_dec) depth_q <= dm1;
      if (cmd_i.out_load)       out_valid_q <= 1'b1;
      else if (!out_stall_i)    out_valid_q <= 1'b0;
    end
  end

  fsee_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.fpu_start),
    .op_i    (cmd_e'(cmd_q)),
    .a_i     (a_q),
    .b_i     (rd_q),
    .done_o  (fpu_done),
    .res_o   (fpu_res)
  );

  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.full     = depth_q >= DW'(STACK_DEPTH);
    stat_o.under2   = depth_q < DW'(2);
    stat_o.empty    = depth_q == '0;
    stat_o.last     = end_q;
    stat_o.fpu_done = fpu_done;
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign printed_value_o = out_val_q;
  assign status_o        = out_status_q;

endmodule

// File: sv/fsee_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing one instruction at a time.
module fsee_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fsee_pkg::dp_stat_t  stat_i,
  output fsee_pkg::ctrl_cmd_t cmd_o
);
  import fsee_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RDA, S_RDB, S_OPB, S_CALC, S_PRP, S_PRL, S_ERR, S_FIN
  } state_e;

  state_e  state_q, state_d;
  status_e err_q, err_d;

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.addr_sel   = ADDR_TOP;
    cmd_o.out_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_PUSH: begin
            if (stat_i.full) begin
              err_d   = ST_OVER;
              state_d = S_ERR;
            end else begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.depth_inc = 1'b1;
              state_d = S_FIN;
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            err_d   = ST_UNDER;
            state_d = stat_i.under2 ? S_ERR : S_RDA;
          end
          CMD_PRINT: begin
            err_d   = ST_UNDER;
            state_d = stat_i.empty ? S_ERR : S_PRP;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_RDA: begin
        cmd_o.addr_sel = ADDR_M1;
        state_d = S_RDB;
      end
      S_RDB: begin
        cmd_o.addr_sel = ADDR_M2;
        cmd_o.cap_a    = 1'b1;
        state_d = S_OPB;
      end
      S_OPB: begin
        cmd_o.addr_sel  = ADDR_M2;
        cmd_o.fpu_start = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.addr_sel = ADDR_M2;
        if (stat_i.fpu_done) begin
          cmd_o.mem_we    = 1'b1;
          cmd_o.wr_fpu    = 1'b1;
          cmd_o.depth_dec = 1'b1;
          state_d = S_FIN;
        end
      end
      S_PRP: begin
        cmd_o.addr_sel = ADDR_M1;
        state_d = S_PRL;
      end
      S_PRL: begin
        cmd_o.addr_sel = ADDR_M1;
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.depth_dec = 1'b1;
          state_d = S_FIN;
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = err_q;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.depth_clr = stat_i.last;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

// File: sv/fp_stack_expression_evaluator_top.sv
`timescale 1ns / 1ps
// Top level of the binary64 RPN stack evaluator.
// One transaction in flight. The shared iterative FPU multiplies in 53 shift-add steps and divides
// in 63 restoring quotient steps; arithmetic also normalises, and multiply and divide first
// prenormalise subnormal operands.
// A waiting result holds back only a later print or error; pushes and arithmetic still finish.
// Reset clears the stack depth and output valid; stack contents are undefined until written.
module fp_stack_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = fsee_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] push_value_i,
  input  logic        program_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] printed_value_o,
  output logic [1:0]  status_o
);
  import fsee_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  fsee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  fsee_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (command_i),
    .push_value_i    (push_value_i),
    .program_end_i   (program_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .printed_value_o (printed_value_o),
    .status_o        (status_o),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the binary64 RPN stack evaluator.
module testbench;
  import fsee_pkg::*;

  localparam int unsigned DEPTH      = STACK_DEPTH_DEF;
  localparam int unsigned CYCLE_CAP  = 3000000;
  localparam int unsigned SETTLE     = 200;
  localparam int unsigned HOLD_LEN   = 2000;
  localparam logic [2:0]  CMD_UNK6   = 3'd6;
  localparam logic [2:0]  CMD_UNK7   = 3'd7;
  localparam logic [63:0] SIGN_M     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] EXP_M      = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] MAN_M      = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] QUIET_M    = 64'h0008_0000_0000_0000;
  localparam logic [63:0] ONE        = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] MAX_FIN    = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_SUB    = 64'h0000_0000_0000_0001;
  localparam logic [63:0] SNAN       = 64'h7FF0_0000_0000_0001;
  localparam logic [63:0] QNAN       = 64'h7FF8_0000_0000_0000;

  typedef struct packed {
    logic [63:0] value;
    status_e     status;
  } print_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = '0;
  logic [63:0] push_value = '0;
  logic        program_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] printed_value;
  logic [1:0]  status;

  logic [63:0] stack_model [DEPTH];
  int unsigned depth_model = 0;
  print_t      expected_prints [$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  logic        long_hold = 1'b0;
  int unsigned sent = 0;

  always #5 clk = ~clk;

  fp_stack_expression_evaluator_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .push_value_i   (push_value),
    .program_end_i  (program_end),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .printed_value_o(printed_value),
    .status_o       (status)
  );

  function automatic logic [63:0] fp_result(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    real x;
    real y;
    real inf;
    x = $bitstoreal(a);
    y = $bitstoreal(b);
    inf = $bitstoreal(EXP_M);
    case (op)
      CMD_ADD: return $realtobits(x + y);
      CMD_SUB: return $realtobits(x - y);
      CMD_MUL: return $realtobits(x * y);
      default: begin
        if ((b & ~SIGN_M) == '0) begin
          if ((a & EXP_M) == EXP_M && (a & MAN_M) != '0) return a | QUIET_M;
          if ((a & ~SIGN_M) == '0) return $realtobits(inf - inf);
          return ((a ^ b) & SIGN_M) | EXP_M;
        end
        return $realtobits(x / y);
      end
    endcase
  endfunction

  function automatic void apply_instruction(logic [2:0] op, logic [63:0] val, logic last);
    print_t p;
    if (op == CMD_PUSH) begin
      if (depth_model >= DEPTH) begin
        p.value = '0; p.status = ST_OVER; expected_prints.push_back(p);
      end else begin
        stack_model[depth_model] = val;
        depth_model++;
      end
    end else if (op >= CMD_ADD && op <= CMD_DIV) begin
      if (depth_model < 2) begin
        p.value = '0; p.status = ST_UNDER; expected_prints.push_back(p);
      end else begin
        stack_model[depth_model-2] =
          fp_result(op, stack_model[depth_model-1], stack_model[depth_model-2]);
        depth_model--;
      end
    end else if (op == CMD_PRINT) begin
      if (depth_model == 0) begin
        p.value = '0; p.status = ST_UNDER;
      end else begin
        depth_model--;
        p.value = stack_model[depth_model]; p.status = ST_OK;
      end
      expected_prints.push_back(p);
    end
    if (last) depth_model = 0;
  endfunction

  task automatic send_instr(logic [2:0] op, logic [63:0] val, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= op;
    push_value  <= val;
    program_end <= last;
    do @(posedge clk); while (in_stall);
    apply_instruction(op, val, last);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_prints.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_fp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return {$urandom, $urandom};
    if (pick < 75)
      return {1'($urandom), 11'($urandom_range(1023 + 40, 1023 - 40)), 20'($urandom), $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return SIGN_M;
      2: return EXP_M;
      3: return EXP_M | SIGN_M;
      4: return QNAN;
      5: return SNAN;
      6: return MIN_SUB;
      7: return MAX_FIN;
      8: return {1'($urandom), 11'd0, 20'($urandom), $urandom};
      default: return ONE;
    endcase
  endfunction

  task automatic random_program();
    int unsigned len;
    logic [2:0]  op;
    len = $urandom_range(20, 2);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) op = 3'($urandom);
      else if (depth_model < 2 || $urandom_range(99) < 35) op = CMD_PUSH;
      else if ($urandom_range(99) < 20) op = CMD_PRINT;
      else op = 3'($urandom_range(CMD_DIV, CMD_ADD));
      send_instr(op, rand_fp(), (i == len - 1) && $urandom_range(1));
    end
    while (depth_model != 0) send_instr(CMD_PRINT, rand_fp(), 1'b0);
  endtask

  task automatic test_operations();
    logic [2:0] ops [4] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
    foreach (ops[i]) begin
      send_instr(CMD_PUSH, 64'h4008_0000_0000_0000, 1'b0);
      send_instr(CMD_PUSH, ONE, 1'b0);
      send_instr(ops[i], '0, 1'b0);
      send_instr(CMD_PRINT, '1, 1'b0);
    end
    send_instr(CMD_PUSH, MAX_FIN, 1'b0);
    send_instr(CMD_PUSH, MAX_FIN, 1'b0);
    send_instr(CMD_ADD, '0, 1'b0);
    send_instr(CMD_PRINT, '0, 1'b0);
    send_instr(CMD_PUSH, '1, 1'b0);
    send_instr(CMD_PRINT, '0, 1'b0);
    drain();
  endtask

  task automatic test_divide_by_zero();
    logic [63:0] dividends [3] = '{64'h4014_0000_0000_0000 | SIGN_M, '0, SNAN};
    foreach (dividends[i]) begin
      send_instr(CMD_PUSH, SIGN_M, 1'b0);
      send_instr(CMD_PUSH, dividends[i], 1'b0);
      send_instr(CMD_DIV, '0, 1'b0);
      send_instr(CMD_PRINT, '0, 1'b0);
    end
    drain();
  endtask

  task automatic test_stack_errors();
    send_instr(CMD_PRINT, '0, 1'b0);
    send_instr(CMD_ADD, '0, 1'b0);
    send_instr(CMD_PUSH, ONE, 1'b0);
    send_instr(CMD_MUL, '0, 1'b1);
    send_instr(CMD_PRINT, '0, 1'b0);
    send_instr(CMD_PUSH, ONE, 1'b0);
    send_instr(CMD_UNK6, '1, 1'b0);
    send_instr(CMD_UNK7, '0, 1'b1);
    send_instr(CMD_PRINT, '0, 1'b0);
    for (int i = 0; i <= DEPTH; i++) send_instr(CMD_PUSH, rand_fp(), 1'b0);
    send_instr(CMD_PUSH, ONE, 1'b1);
    send_instr(CMD_PRINT, '0, 1'b0);
    drain();
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall, int unsigned items);
    int unsigned start;
    idle_pct  = idle;
    stall_pct = stall;
    start = sent;
    while (sent - start < items) random_program();
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_instr(CMD_PUSH, rand_fp(), 1'b0);
      send_instr(CMD_PRINT, '0, 1'b0);
    end
    drain();
    long_hold = 1'b0;
  endtask

  always @(posedge clk) begin
    if (long_hold && hold_cycles < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    print_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_prints.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result %h status %0d", printed_value, status);
      end else begin
        e = expected_prints.pop_front();
        if (printed_value !== e.value || status !== e.status) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected %h/%0d, got %h/%0d",
                     e.value, e.status, printed_value, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operations();
    test_divide_by_zero();
    test_stack_errors();
    test_random_phase(0, 0, 480);
    test_random_phase(48, 0, 400);
    test_random_phase(0, 48, 400);
    test_random_phase(9, 9, 450);
    test_backpressure();
    if (failures == 0 && expected_prints.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
